// File: rtl/core/dfrm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dfrm_pkg;

  localparam int unsigned MarkerLen = 8;
  localparam int unsigned HdrLen    = 4;

  localparam logic [2:0]  MARKER_LAST = 3'(MarkerLen - 1);
  localparam logic [2:0]  HDR_DONE    = 3'(HdrLen);
  localparam logic [31:0] MIN_LEN     = 32'(HdrLen);

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } dfrm_item_t;

  function automatic logic [7:0] marker_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0: c = 8'h53;
      3'd1: c = 8'h41;
      3'd2: c = 8'h54;
      3'd3: c = 8'h53;
      3'd4: c = 8'h49;
      3'd5: c = 8'h44;
      3'd6: c = 8'h45;
      3'd7: c = 8'h42;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/marker_switched_message_deframer.sv
// Marker-switched message deframer for one trace channel.
// Input channel: in_valid / in_stall / in_payload_byte, one payload byte per
// request.
// Result channel: out_valid / out_stall with out_byte, out_in_message_mode,
// out_message_last and out_length_error.
// The block starts in raw mode and passes bytes through while it watches for
// the eight-byte marker; the final marker byte is swallowed and the channel
// switches to message mode until reset. In message mode, zero bytes between
// messages are dropped, the 4-byte little-endian length header is passed on
// and the last byte of each message is flagged.
// A request taken by the input register passes on to the result register and
// is then offered on the result channel.
// One request per cycle while out_stall is low, set by the state update
// between the two registers.
// Reset (rst_n low, synchronous) returns to raw mode and empties both stages.
// When out_stall is high the result holds, the input register fills and
// in_stall then rises; no request is lost.
`timescale 1ns / 1ps
`default_nettype none

module marker_switched_message_deframer import dfrm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_payload_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_in_message_mode,
  output logic            out_message_last,
  output logic            out_length_error
);

  dfrm_item_t item;
  logic       advance;

  dfrm_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_payload_byte),
    .advance  (advance),
    .item     (item)
  );

  dfrm_core u_core (
    .clk                 (clk),
    .rst_n               (rst_n),
    .item                (item),
    .advance             (advance),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_byte            (out_byte),
    .out_in_message_mode (out_in_message_mode),
    .out_message_last    (out_message_last),
    .out_length_error    (out_length_error)
  );

endmodule

`default_nettype wire

// File: rtl/core/dfrm_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module dfrm_in_reg import dfrm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data,
  input  wire logic       advance,
  output dfrm_item_t      item
);

  logic       valid_r;
  logic [7:0] data_r;

  assign in_stall = valid_r && !advance;
  assign item     = '{valid: valid_r, data: data_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
    if (in_valid && !in_stall) begin
      data_r <= in_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/dfrm_core.sv
`timescale 1ns / 1ps
`default_nettype none

module dfrm_core import dfrm_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire dfrm_item_t item,
  output logic            advance,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            out_in_message_mode,
  output logic            out_message_last,
  output logic            out_length_error
);

  logic        mode_r, mode_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic [2:0]  hbs_r, hbs_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] sent_r, sent_nxt;

  logic        valid_r;
  logic [7:0]  byte_r;
  logic        mm_r, last_r, err_r;

  logic        consume;
  logic        emit;
  logic        last, err;
  logic [7:0]  b;

  assign advance = !valid_r || !out_stall;
  assign consume = item.valid && advance;
  assign b       = item.data;

  always_comb begin
    mode_nxt = mode_r;
    pos_nxt  = pos_r;
    hbs_nxt  = hbs_r;
    len_nxt  = len_r;
    sent_nxt = sent_r;
    emit     = 1'b0;
    last     = 1'b0;
    err      = 1'b0;
    if (!mode_r) begin
      emit = 1'b1;
      if (b == marker_char(pos_r)) begin
        if (pos_r == MARKER_LAST) begin
          pos_nxt  = 3'd0;
          mode_nxt = 1'b1;
          hbs_nxt  = 3'd0;
          len_nxt  = '0;
          sent_nxt = '0;
          emit     = 1'b0;
        end else begin
          pos_nxt = pos_r + 3'd1;
        end
      end else begin
        pos_nxt = (b == marker_char(3'd0)) ? 3'd1 : 3'd0;
      end
    end else if (!(hbs_r == 3'd0 && b == 8'h00)) begin
      emit = 1'b1;
      if (hbs_r < HDR_DONE) begin
        len_nxt = len_r | ({24'd0, b} << {hbs_r[1:0], 3'b000});
        hbs_nxt = hbs_r + 3'd1;
        if (hbs_nxt == HDR_DONE && len_nxt < MIN_LEN) begin
          len_nxt = MIN_LEN;
          err     = 1'b1;
        end
      end
      sent_nxt = sent_r + 32'd1;
      if (hbs_nxt == HDR_DONE && sent_nxt >= len_nxt) begin
        last     = 1'b1;
        hbs_nxt  = 3'd0;
        len_nxt  = '0;
        sent_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      pos_r   <= 3'd0;
      hbs_r   <= 3'd0;
      len_r   <= '0;
      sent_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      if (consume) begin
        mode_r <= mode_nxt;
        pos_r  <= pos_nxt;
        hbs_r  <= hbs_nxt;
        len_r  <= len_nxt;
        sent_r <= sent_nxt;
      end
      if (advance) begin
        valid_r <= consume && emit;
      end
    end
    if (consume && emit) begin
      byte_r <= b;
      mm_r   <= mode_r;
      last_r <= last;
      err_r  <= err;
    end
  end

  assign out_valid           = valid_r;
  assign out_byte            = byte_r;
  assign out_in_message_mode = mm_r;
  assign out_message_last    = last_r;
  assign out_length_error    = err_r;

  a_mode_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r |=> mode_r) else $error("message mode dropped without reset");

  a_hdr_range: assert property (@(posedge clk) disable iff (!rst_n)
    hbs_r <= HDR_DONE) else $error("header count out of range");

  a_pos_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r |-> pos_r == 3'd0) else $error("marker matcher active in message mode");

  a_last_mode: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && last_r |-> mm_r) else $error("last flag on raw byte");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && err_r |-> mm_r && last_r) else $error("short length not ending message");

endmodule

`default_nettype wire
